@@ design/mf3_pkg.sv @@
package mf3_pkg;

    // Defaults for the top-level parameters.
    localparam int MAX_WIDTH_DEF = 2048;
    localparam int CHANNELS_DEF  = 3;

    // Field widths fixed by the pixel format and the register map.
    localparam int CH_W       = 8;
    localparam int PIX24_W    = 24;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;
    localparam int ROW_W      = 12;

    // Result queue that decouples the filter pipeline from the output port.
    localparam int QUEUE_DEPTH = 8;

    // Register indexes on the configuration channel.
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_THREE_CHANNELS = 2'd2;

    localparam logic [CFG_DATA_W-1:0] WIDTH_RESET  = 12'd640;
    localparam logic [CFG_DATA_W-1:0] HEIGHT_RESET = 12'd480;
    localparam int MIN_DIM = 3;

    typedef logic [CH_W-1:0] chan_t;

    // Per-item position flags, worked out when the pixel is taken in.
    typedef struct packed {
        logic emit;
        logic use_med;
        logic last_row;
        logic last_col;
    } mf3_flags_t;

    // One queue entry: everything needed to produce the one, two or four
    // results of a single input pixel.
    typedef struct packed {
        logic [PIX24_W-1:0] centre;
        logic [PIX24_W-1:0] row_copy;
        logic [PIX24_W-1:0] col_copy;
        logic [PIX24_W-1:0] corner;
        logic               last_row;
        logic               last_col;
    } mf3_rec_t;

    // Which result of the current entry is on the output port.
    typedef enum logic [1:0] {
        STEP_CENTRE,
        STEP_ROW,
        STEP_COL,
        STEP_CORNER
    } mf3_step_t;

    function automatic chan_t min2(input chan_t a, input chan_t b);
        return (a < b) ? a : b;
    endfunction

    function automatic chan_t max2(input chan_t a, input chan_t b);
        return (a > b) ? a : b;
    endfunction

    function automatic chan_t min3(input chan_t a, input chan_t b, input chan_t c);
        return min2(min2(a, b), c);
    endfunction

    function automatic chan_t max3(input chan_t a, input chan_t b, input chan_t c);
        return max2(max2(a, b), c);
    endfunction

    function automatic chan_t med3(input chan_t a, input chan_t b, input chan_t c);
        return max2(min2(a, b), min2(max2(a, b), c));
    endfunction

endpackage

@@ design/mf3_if.sv @@
interface mf3_pix_if
    import mf3_pkg::*;
;
    logic  valid;
    logic  ready;
    chan_t chan_a;
    chan_t chan_b;
    chan_t chan_c;

    modport source (output valid, output chan_a, output chan_b, output chan_c, input ready);
    modport sink   (input valid, input chan_a, input chan_b, input chan_c, output ready);
endinterface

interface mf3_res_if
    import mf3_pkg::*;
;
    logic  valid;
    logic  ready;
    chan_t out_a;
    chan_t out_b;
    chan_t out_c;
    logic  last_of_run;
    logic  frame_end;

    modport source (output valid, output out_a, output out_b, output out_c,
                    output last_of_run, output frame_end, input ready);
    modport sink   (input valid, input out_a, input out_b, input out_c,
                    input last_of_run, input frame_end, output ready);
endinterface

interface mf3_cfg_if
    import mf3_pkg::*;
;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

@@ design/median_filter_3x3_top.sv @@
// 3x3 median filter for a raster pixel stream. Pixels arrive one per request
// on the pixel channel in raster order, either grey (chan_a only) or with
// three interleaved 8-bit colour channels, and each interior pixel leaves on
// the result channel replaced, channel by channel, by the median of its 3x3
// neighbourhood; pixels of the first and last rows and columns leave
// unchanged. Results trail the input by one row and one column: the pixel at
// row r, column c releases the result for row r-1, column c-1, the last pixel
// of a row also releases the last column, and the last input row also flushes
// the last output row, so one input request gives zero, one, two or four
// results, with last_of_run on the final one and frame_end on the
// bottom-right pixel of the frame. The block takes one pixel per clock while
// the result queue has room, and the output side moves one result per clock
// while result.ready is high. On the last row, where a pixel gives two or
// four results, the output port sets the pace and the eight-entry result
// queue throttles the input. The two line stores share one dual-port RAM of
// MAX_WIDTH entries; each pixel reads its column in the cycle it is taken and
// writes it back in the next cycle, and no clearing pass is needed after
// reset. Width, height and colour mode are to be written on the configuration
// channel while the block is idle; the block itself does not enforce this.
// Width is held to 3..MAX_WIDTH and height to at least 3.
module median_filter_3x3_top
    import mf3_pkg::*;
#(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF,
    parameter int CHANNELS  = CHANNELS_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    mf3_cfg_if.sink   cfg,
    mf3_pix_if.sink   pixel,
    mf3_res_if.source result
);

    localparam int ADDR_W  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int PW      = CH_W * CHANNELS;
    localparam int CMP_W   = ((ADDR_W > CFG_DATA_W) ? ADDR_W : CFG_DATA_W) + 1;
    localparam int Q_CNT_W = $clog2(QUEUE_DEPTH + 1);

    // ------------------------------------------------------------------
    // Configuration registers. The channel is always ready.
    // ------------------------------------------------------------------
    logic [CFG_DATA_W-1:0] width_reg;
    logic [CFG_DATA_W-1:0] height_reg;
    logic                  three_ch_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg    <= WIDTH_RESET;
            height_reg   <= HEIGHT_RESET;
            three_ch_reg <= 1'b0;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_IMAGE_WIDTH:    width_reg    <= cfg.data;
                REG_IMAGE_HEIGHT:   height_reg   <= cfg.data;
                REG_THREE_CHANNELS: three_ch_reg <= cfg.data[0];
                default:
                begin
                end
            endcase
        end
    end

    // Last column and last row after the width and height are held to their
    // legal ranges.
    logic [CMP_W-1:0]  width_ext;
    logic [ADDR_W-1:0] w_last;
    logic [ROW_W-1:0]  h_last;

    assign width_ext = CMP_W'(width_reg);

    always_comb
    begin
        if (width_ext < CMP_W'(MIN_DIM))
        begin
            w_last = ADDR_W'(MIN_DIM - 1);
        end
        else if (width_ext > CMP_W'(MAX_WIDTH))
        begin
            w_last = ADDR_W'(MAX_WIDTH - 1);
        end
        else
        begin
            w_last = ADDR_W'(width_ext - CMP_W'(1));
        end

        if (height_reg < ROW_W'(MIN_DIM))
        begin
            h_last = ROW_W'(MIN_DIM - 1);
        end
        else
        begin
            h_last = height_reg - ROW_W'(1);
        end
    end

    // ------------------------------------------------------------------
    // Position counters. A count beyond the current last column or row,
    // possible only after the dimensions were rewritten mid-frame, is taken
    // as that last column or row.
    // ------------------------------------------------------------------
    logic [ADDR_W-1:0] col_reg;
    logic [ROW_W-1:0]  row_reg;
    logic [ADDR_W-1:0] col_cur;
    logic [ROW_W-1:0]  row_cur;
    logic              accept;
    logic              in_ready;
    mf3_flags_t        in_flags;
    logic [PIX24_W-1:0] in_pix24;
    logic [PW-1:0]     in_pix;

    assign col_cur = (col_reg > w_last) ? w_last : col_reg;
    assign row_cur = (row_reg > h_last) ? h_last : row_reg;
    assign accept  = pixel.valid && in_ready;
    assign pixel.ready = in_ready;

    // In grey mode the second and third channels are stored as zero.
    assign in_pix24 = three_ch_reg ? {pixel.chan_c, pixel.chan_b, pixel.chan_a}
                                   : {16'b0, pixel.chan_a};
    assign in_pix   = in_pix24[PW-1:0];

    // A pixel releases a result once it is past the first row and column; the
    // released pixel is interior only when both counts are at least two.
    always_comb
    begin
        in_flags.emit     = (row_cur != '0) && (col_cur != '0);
        in_flags.use_med  = (row_cur > ROW_W'(1)) && (col_cur > ADDR_W'(1));
        in_flags.last_row = (row_cur == h_last);
        in_flags.last_col = (col_cur == w_last);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (accept)
        begin
            if (col_cur == w_last)
            begin
                col_reg <= '0;
                row_reg <= (row_cur == h_last) ? '0 : row_cur + ROW_W'(1);
            end
            else
            begin
                col_reg <= col_cur + ADDR_W'(1);
                row_reg <= row_cur;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: the line store read issued at accept returns. Each RAM entry
    // holds the upper line in its top half and the middle line in its bottom
    // half; the entry is rewritten with the middle value moved up and the new
    // pixel in the middle. Two pixels in a row never share a column, so the
    // write-back never meets a read of the same entry.
    // ------------------------------------------------------------------
    logic              v1_reg;
    logic [PW-1:0]     pix1_reg;
    logic [ADDR_W-1:0] col1_reg;
    mf3_flags_t        flags1_reg;
    logic [2*PW-1:0]   ram_rdata;
    logic [PW-1:0]     ram_top;
    logic [PW-1:0]     ram_mid;

    mf3_ram #(
        .WIDTH (2 * PW),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .clk   (clk),
        .we    (v1_reg),
        .waddr (col1_reg),
        .wdata ({ram_mid, pix1_reg}),
        .re    (accept),
        .raddr (col_cur),
        .rdata (ram_rdata)
    );

    assign ram_top = ram_rdata[2*PW-1:PW];
    assign ram_mid = ram_rdata[PW-1:0];

    // The 3x3 window shifts left by one column for every pixel taken; the new
    // right column is upper line, middle line and incoming pixel.
    logic [PW-1:0] win_reg [3][3];
    logic [PW-1:0] win_new [3][3];

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            win_new[k][0] = win_reg[k][1];
            win_new[k][1] = win_reg[k][2];
        end
        win_new[0][2] = ram_top;
        win_new[1][2] = ram_mid;
        win_new[2][2] = pix1_reg;
    end

    always_ff @(posedge clk)
    begin
        if (v1_reg)
        begin
            win_reg <= win_new;
        end
    end

    // Each column of the new window is sorted per channel on its way into
    // stage 2.
    chan_t lo_next [3][CHANNELS];
    chan_t md_next [3][CHANNELS];
    chan_t hi_next [3][CHANNELS];

    always_comb
    begin
        for (int j = 0; j < 3; j++)
        begin
            for (int ch = 0; ch < CHANNELS; ch++)
            begin
                lo_next[j][ch] = min3(win_new[0][j][ch*CH_W +: CH_W],
                                      win_new[1][j][ch*CH_W +: CH_W],
                                      win_new[2][j][ch*CH_W +: CH_W]);
                md_next[j][ch] = med3(win_new[0][j][ch*CH_W +: CH_W],
                                      win_new[1][j][ch*CH_W +: CH_W],
                                      win_new[2][j][ch*CH_W +: CH_W]);
                hi_next[j][ch] = max3(win_new[0][j][ch*CH_W +: CH_W],
                                      win_new[1][j][ch*CH_W +: CH_W],
                                      win_new[2][j][ch*CH_W +: CH_W]);
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: sorted columns plus the four window pixels that border
    // results copy. Pixels that release nothing stop here.
    // ------------------------------------------------------------------
    logic       v2_reg;
    mf3_flags_t flags2_reg;
    logic [PW-1:0] ctr2_reg;
    logic [PW-1:0] rowc2_reg;
    logic [PW-1:0] colc2_reg;
    logic [PW-1:0] crn2_reg;
    chan_t lo2_reg [3][CHANNELS];
    chan_t md2_reg [3][CHANNELS];
    chan_t hi2_reg [3][CHANNELS];

    // The median of nine is the median of the largest column minimum, the
    // median of the column medians and the smallest column maximum.
    chan_t maxlo_next [CHANNELS];
    chan_t medmd_next [CHANNELS];
    chan_t minhi_next [CHANNELS];

    always_comb
    begin
        for (int ch = 0; ch < CHANNELS; ch++)
        begin
            maxlo_next[ch] = max3(lo2_reg[0][ch], lo2_reg[1][ch], lo2_reg[2][ch]);
            medmd_next[ch] = med3(md2_reg[0][ch], md2_reg[1][ch], md2_reg[2][ch]);
            minhi_next[ch] = min3(hi2_reg[0][ch], hi2_reg[1][ch], hi2_reg[2][ch]);
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: three candidates per channel; the final median of three is
    // formed on the way into the result queue.
    // ------------------------------------------------------------------
    logic       v3_reg;
    mf3_flags_t flags3_reg;
    logic [PW-1:0] ctr3_reg;
    logic [PW-1:0] rowc3_reg;
    logic [PW-1:0] colc3_reg;
    logic [PW-1:0] crn3_reg;
    chan_t maxlo3_reg [CHANNELS];
    chan_t medmd3_reg [CHANNELS];
    chan_t minhi3_reg [CHANNELS];

    logic [PW-1:0] med_pix;
    logic [PW-1:0] centre_pix;
    mf3_rec_t      push_rec;

    always_comb
    begin
        for (int ch = 0; ch < CHANNELS; ch++)
        begin
            med_pix[ch*CH_W +: CH_W] = med3(maxlo3_reg[ch], medmd3_reg[ch], minhi3_reg[ch]);
        end
        centre_pix        = flags3_reg.use_med ? med_pix : ctr3_reg;
        push_rec.centre   = PIX24_W'(centre_pix);
        push_rec.row_copy = PIX24_W'(rowc3_reg);
        push_rec.col_copy = PIX24_W'(colc3_reg);
        push_rec.corner   = PIX24_W'(crn3_reg);
        push_rec.last_row = flags3_reg.last_row;
        push_rec.last_col = flags3_reg.last_col;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= accept;
            v2_reg <= v1_reg && flags1_reg.emit;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pix1_reg   <= in_pix;
            col1_reg   <= col_cur;
            flags1_reg <= in_flags;
        end
        if (v1_reg)
        begin
            flags2_reg <= flags1_reg;
            ctr2_reg   <= win_new[1][1];
            rowc2_reg  <= win_new[2][1];
            colc2_reg  <= win_new[1][2];
            crn2_reg   <= win_new[2][2];
            lo2_reg    <= lo_next;
            md2_reg    <= md_next;
            hi2_reg    <= hi_next;
        end
        if (v2_reg)
        begin
            flags3_reg <= flags2_reg;
            ctr3_reg   <= ctr2_reg;
            rowc3_reg  <= rowc2_reg;
            colc3_reg  <= colc2_reg;
            crn3_reg   <= crn2_reg;
            maxlo3_reg <= maxlo_next;
            medmd3_reg <= medmd_next;
            minhi3_reg <= minhi_next;
        end
    end

    // ------------------------------------------------------------------
    // Result queue. A new pixel is taken only while the queue has room for
    // every pixel already in the pipeline plus this one, so nothing in the
    // pipeline ever has to stall.
    // ------------------------------------------------------------------
    logic [Q_CNT_W-1:0] q_count;
    logic [Q_CNT_W:0]   occupancy;

    assign occupancy = (Q_CNT_W + 1)'(q_count) + (Q_CNT_W + 1)'(v1_reg)
                     + (Q_CNT_W + 1)'(v2_reg) + (Q_CNT_W + 1)'(v3_reg);
    assign in_ready  = (occupancy < (Q_CNT_W + 1)'(QUEUE_DEPTH));

    mf3_out_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_out_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (v3_reg),
        .push_rec (push_rec),
        .count    (q_count),
        .result   (result)
    );

endmodule

@@ design/mf3_ram.sv @@
module mf3_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ design/mf3_out_queue.sv @@
module mf3_out_queue
    import mf3_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CNT_W = $clog2(DEPTH + 1)
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  mf3_rec_t         push_rec,
    output logic [CNT_W-1:0] count,
    mf3_res_if.source        result
);

    mf3_rec_t         rec_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg;
    logic [AW-1:0]    rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    mf3_step_t        step_reg;
    mf3_step_t        step_next;
    mf3_step_t        step_after;
    logic             step_done;
    logic             fire;
    logic             pop;
    mf3_rec_t         head;
    logic [PIX24_W-1:0] sel_pix;

    assign head  = rec_reg[rd_ptr_reg];
    assign fire  = result.valid && result.ready;
    assign pop   = fire && step_done;
    assign count = count_reg;

    // Order of results for one entry: centre, then the last-row copy below
    // it, then the last-column copy, then the bottom-right corner.
    always_comb
    begin
        step_after = STEP_CENTRE;
        step_done  = 1'b1;
        unique case (step_reg)
            STEP_CENTRE:
            begin
                if (head.last_row)
                begin
                    step_after = STEP_ROW;
                    step_done  = 1'b0;
                end
                else if (head.last_col)
                begin
                    step_after = STEP_COL;
                    step_done  = 1'b0;
                end
            end
            STEP_ROW:
            begin
                if (head.last_col)
                begin
                    step_after = STEP_COL;
                    step_done  = 1'b0;
                end
            end
            STEP_COL:
            begin
                if (head.last_row)
                begin
                    step_after = STEP_CORNER;
                    step_done  = 1'b0;
                end
            end
            STEP_CORNER:
            begin
                step_done = 1'b1;
            end
            default:
            begin
                step_done = 1'b1;
            end
        endcase
    end

    always_comb
    begin
        step_next = step_reg;
        if (fire)
        begin
            step_next = step_done ? STEP_CENTRE : step_after;
        end
    end

    always_comb
    begin
        unique case (step_reg)
            STEP_CENTRE: sel_pix = head.centre;
            STEP_ROW:    sel_pix = head.row_copy;
            STEP_COL:    sel_pix = head.col_copy;
            STEP_CORNER: sel_pix = head.corner;
            default:     sel_pix = head.centre;
        endcase
        result.valid       = (count_reg != '0);
        result.out_a       = sel_pix[7:0];
        result.out_b       = sel_pix[15:8];
        result.out_c       = sel_pix[23:16];
        result.last_of_run = step_done;
        result.frame_end   = (step_reg == STEP_CORNER);
    end

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (!push && pop)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
            step_reg   <= STEP_CENTRE;
        end
        else
        begin
            count_reg <= count_next;
            step_reg  <= step_next;
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            rec_reg[wr_ptr_reg] <= push_rec;
        end
    end

endmodule

@@ design/mf3_checker.sv @@
module mf3_checker
    import mf3_pkg::*;
(
    input logic  clk,
    input logic  rst_n,
    input logic  pix_valid,
    input logic  pix_ready,
    input logic  res_valid,
    input logic  res_ready,
    input chan_t res_a,
    input chan_t res_b,
    input chan_t res_c,
    input logic  res_last,
    input logic  res_fend
);

    logic seen_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg <= 1'b0;
        end
        else if (pix_valid && pix_ready)
        begin
            seen_reg <= 1'b1;
        end
    end

    // A result offered while stalled stays offered.
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid)
        else $error("result request dropped while stalled");

    // A stalled result keeps its payload.
    a_res_stable: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> $stable({res_a, res_b, res_c, res_last, res_fend}))
        else $error("result payload changed while stalled");

    // The frame's last pixel is always the final result of its run.
    a_fend_last: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_fend |-> res_last)
        else $error("frame_end without last_of_run");

    // No result can appear before any pixel was taken.
    a_no_early: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> seen_reg)
        else $error("result offered before any pixel was taken");

endmodule

bind median_filter_3x3_top mf3_checker u_mf3_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .pix_valid (pixel.valid),
    .pix_ready (pixel.ready),
    .res_valid (result.valid),
    .res_ready (result.ready),
    .res_a     (result.out_a),
    .res_b     (result.out_b),
    .res_c     (result.out_c),
    .res_last  (result.last_of_run),
    .res_fend  (result.frame_end)
);
